FILE: hdl/lru_slot_cache_tags_macros.svh
// Assertion helpers for the tag store.
`ifndef LRU_SLOT_CACHE_TAGS_MACROS_SVH
`define LRU_SLOT_CACHE_TAGS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSCT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsct: implication check failed");
`define LSCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsct: next-cycle check failed");
`define LSCT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lsct: invariant check failed");
`else
`define LSCT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`define LSCT_ASSERT_ALWAYS(label, clk, rst, expr)
`endif
`endif

FILE: hdl/lsct_pkg.sv
package lsct_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int TAG_BITS    = 16;
   localparam int STAMP_BITS  = 32;

   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int CFG_W   = 5;
   localparam int ID_W    = 16;
   localparam int SLOT_W  = 4;
   localparam int CODE_W  = 3;
   localparam int TOTAL_W = 32;

   typedef enum logic [1:0] {
      ENT_EMPTY   = 2'd0,
      ENT_LOADING = 2'd1,
      ENT_READY   = 2'd2,
      ENT_IN_USE  = 2'd3
   } ent_state_type;

   typedef enum logic [CODE_W-1:0] {
      RSP_HIT       = 3'd0,
      RSP_MISS      = 3'd1,
      RSP_NO_VICTIM = 3'd2,
      RSP_LOADED    = 3'd3,
      RSP_FAILED    = 3'd4,
      RSP_BAD_SLOT  = 3'd5
   } rsp_code_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_HIT_SCAN,
      FSM_VIC_SCAN,
      FSM_RESERVE,
      FSM_COMPLETE
   } fsm_state_type;

   typedef struct packed {
      logic load;
      logic clr_idx;
      logic inc_idx;
      logic vic_check;
      logic do_hit;
      logic do_reserve;
      logic do_novictim;
      logic do_complete;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_complete;
      logic scan_end;
      logic hit_match;
      logic elig_empty;
      logic vic_found;
   } dp_stat_type;

endpackage

FILE: hdl/lsct_ctrl.sv
module lsct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lsct_pkg::dp_stat_type stat,
   output lsct_pkg::ctl_cmd_type cmd
);

   lsct_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsct_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsct_pkg::FSM_IDLE: begin
            if (start) begin
               state_in = stat.is_complete ? lsct_pkg::FSM_COMPLETE : lsct_pkg::FSM_HIT_SCAN;
            end
         end
         lsct_pkg::FSM_HIT_SCAN: begin
            priority if (stat.scan_end) begin
               state_in = lsct_pkg::FSM_VIC_SCAN;
            end else if (stat.hit_match) begin
               state_in = lsct_pkg::FSM_IDLE;
            end else begin
               state_in = lsct_pkg::FSM_HIT_SCAN;
            end
         end
         lsct_pkg::FSM_VIC_SCAN: begin
            priority if (stat.scan_end) begin
               state_in = stat.vic_found ? lsct_pkg::FSM_RESERVE : lsct_pkg::FSM_IDLE;
            end else if (stat.elig_empty) begin
               state_in = lsct_pkg::FSM_RESERVE;
            end else begin
               state_in = lsct_pkg::FSM_VIC_SCAN;
            end
         end
         lsct_pkg::FSM_RESERVE:  state_in = lsct_pkg::FSM_IDLE;
         lsct_pkg::FSM_COMPLETE: state_in = lsct_pkg::FSM_IDLE;
         default:                state_in = lsct_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         lsct_pkg::FSM_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         lsct_pkg::FSM_HIT_SCAN: begin
            priority if (stat.scan_end) begin
               cmd.clr_idx = 1'b1;
            end else if (stat.hit_match) begin
               cmd.do_hit = 1'b1;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         lsct_pkg::FSM_VIC_SCAN: begin
            if (stat.scan_end) begin
               cmd.do_novictim = !stat.vic_found;
            end else begin
               cmd.vic_check = 1'b1;
               cmd.inc_idx   = !stat.elig_empty;
            end
         end
         lsct_pkg::FSM_RESERVE:  cmd.do_reserve  = 1'b1;
         lsct_pkg::FSM_COMPLETE: cmd.do_complete = 1'b1;
         default:                busy = 1'b1;
      endcase
   end

endmodule

FILE: hdl/lsct_dpath.sv
`include "lru_slot_cache_tags_macros.svh"

module lsct_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  lsct_pkg::ctl_cmd_type         cmd,
   output lsct_pkg::dp_stat_type         stat,
   input  logic [lsct_pkg::CFG_W-1:0]    active_entries,
   input  logic                          req_command,
   input  logic [lsct_pkg::ID_W-1:0]     req_expert_id,
   input  logic [lsct_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          req_load_ok,
   output logic                          rsp_valid,
   output logic [lsct_pkg::CODE_W-1:0]   rsp_status,
   output logic [lsct_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [lsct_pkg::TOTAL_W-1:0]  rsp_hits_total,
   output logic [lsct_pkg::TOTAL_W-1:0]  rsp_misses_total,
   output logic [lsct_pkg::TOTAL_W-1:0]  rsp_evictions_total
);

   localparam int N  = lsct_pkg::MAX_ENTRIES;
   localparam int IW = lsct_pkg::IDX_W;
   localparam int CW = lsct_pkg::CNT_W;
   localparam int TW = lsct_pkg::TAG_BITS;
   localparam int SW = lsct_pkg::STAMP_BITS;
   localparam int OW = lsct_pkg::TOTAL_W;

   // entry store
   logic [TW-1:0]              tag_ff   [N];
   logic [SW-1:0]              stamp_ff [N];
   lsct_pkg::ent_state_type    status_ff[N];
   logic                       held_ff  [N];

   // per-item registers
   logic                       cmd_ff;
   logic [TW-1:0]              req_tag_ff;
   logic                       load_ok_ff;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [IW-1:0]              vic_ff, vic_in;
   logic [SW-1:0]              best_ff, best_in;
   logic                       found_ff, found_in;
   logic                       vic_ready_ff, vic_ready_in;

   logic [SW-1:0]              use_clock_ff, use_clock_in;
   logic [OW-1:0]              hits_ff, hits_in;
   logic [OW-1:0]              misses_ff, misses_in;
   logic [OW-1:0]              evicts_ff, evicts_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   lsct_pkg::rsp_code_type     rsp_status_ff, rsp_status_in;
   logic [lsct_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // write port
   logic                       ent_we;
   logic                       tag_we;
   logic                       stamp_we;
   logic [IW-1:0]              wr_idx;
   lsct_pkg::ent_state_type    ent_status_in;
   logic                       ent_held_in;

   logic [CW-1:0]              n_live;
   logic [IW-1:0]              rd_idx;
   logic [TW-1:0]              tag_rd;
   logic [SW-1:0]              stamp_rd;
   lsct_pkg::ent_state_type    st_rd;
   logic                       held_rd;
   logic                       scan_end;
   logic                       elig;
   logic                       slot_ok;
   logic [N-1:0]               held_vec, loading_vec;

   always_comb begin
      if (32'(active_entries) > 32'(N)) begin
         n_live = CW'(N);
      end else begin
         n_live = CW'(active_entries);
      end
   end

   assign rd_idx   = idx_ff[IW-1:0];
   assign tag_rd   = tag_ff[rd_idx];
   assign stamp_rd = stamp_ff[rd_idx];
   assign st_rd    = status_ff[rd_idx];
   assign held_rd  = held_ff[rd_idx];
   assign scan_end = (idx_ff >= n_live);
   assign elig     = !held_rd &&
                     (st_rd == lsct_pkg::ENT_EMPTY || st_rd == lsct_pkg::ENT_READY);
   assign slot_ok  = !scan_end && (st_rd == lsct_pkg::ENT_LOADING);

   assign stat.is_complete = req_command;
   assign stat.scan_end    = scan_end;
   assign stat.hit_match   = !scan_end && (st_rd == lsct_pkg::ENT_READY) &&
                             (tag_rd == req_tag_ff);
   assign stat.elig_empty  = !scan_end && elig && (st_rd == lsct_pkg::ENT_EMPTY);
   assign stat.vic_found   = found_ff;

   always_comb begin
      idx_in       = idx_ff;
      vic_in       = vic_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      vic_ready_in = vic_ready_ff;
      use_clock_in = use_clock_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in  = rsp_slot_ff;
      ent_we       = 1'b0;
      tag_we       = 1'b0;
      stamp_we     = 1'b0;
      wr_idx       = rd_idx;
      ent_status_in = st_rd;
      ent_held_in  = held_rd;

      if (cmd.load) begin
         idx_in   = req_command ? CW'(req_slot) : '0;
         found_in = 1'b0;
      end
      if (cmd.clr_idx) begin
         idx_in = '0;
      end
      if (cmd.inc_idx) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.vic_check && elig) begin
         if (st_rd == lsct_pkg::ENT_EMPTY) begin
            vic_in       = rd_idx;
            found_in     = 1'b1;
            vic_ready_in = 1'b0;
         end else if (!found_ff || stamp_rd < best_ff) begin
            vic_in       = rd_idx;
            best_in      = stamp_rd;
            found_in     = 1'b1;
            vic_ready_in = 1'b1;
         end
      end
      if (cmd.do_hit) begin
         hits_in       = hits_ff + OW'(1);
         use_clock_in  = use_clock_ff + SW'(1);
         stamp_we      = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsct_pkg::RSP_HIT;
         rsp_slot_in   = lsct_pkg::SLOT_W'(idx_ff);
      end
      if (cmd.do_reserve) begin
         misses_in     = misses_ff + OW'(1);
         if (vic_ready_ff) begin
            evicts_in = evicts_ff + OW'(1);
         end
         use_clock_in  = use_clock_ff + SW'(1);
         wr_idx        = vic_ff;
         ent_we        = 1'b1;
         tag_we        = 1'b1;
         stamp_we      = 1'b1;
         ent_status_in = lsct_pkg::ENT_LOADING;
         ent_held_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsct_pkg::RSP_MISS;
         rsp_slot_in   = lsct_pkg::SLOT_W'(vic_ff);
      end
      if (cmd.do_novictim) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsct_pkg::RSP_NO_VICTIM;
         rsp_slot_in   = '0;
      end
      if (cmd.do_complete) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = lsct_pkg::SLOT_W'(idx_ff);
         if (!slot_ok) begin
            rsp_status_in = lsct_pkg::RSP_BAD_SLOT;
         end else begin
            ent_we        = 1'b1;
            ent_held_in   = 1'b0;
            ent_status_in = load_ok_ff ? lsct_pkg::ENT_READY : lsct_pkg::ENT_EMPTY;
            rsp_status_in = load_ok_ff ? lsct_pkg::RSP_LOADED : lsct_pkg::RSP_FAILED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            status_ff[i] <= lsct_pkg::ENT_EMPTY;
            held_ff[i]   <= 1'b0;
         end
      end else if (ent_we) begin
         status_ff[wr_idx] <= ent_status_in;
         held_ff[wr_idx]   <= ent_held_in;
      end
   end

   // stamps are only compared on ready entries, which always carry one
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_ff[wr_idx] <= req_tag_ff;
      end
      if (stamp_we) begin
         stamp_ff[wr_idx] <= use_clock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         vic_ready_ff <= 1'b0;
         use_clock_ff <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         vic_ready_ff <= vic_ready_in;
         use_clock_ff <= use_clock_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= req_command;
         req_tag_ff <= req_expert_id[TW-1:0];
         load_ok_ff <= req_load_ok;
      end
      vic_ff        <= vic_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_hits_total      = hits_ff;
   assign rsp_misses_total    = misses_ff;
   assign rsp_evictions_total = evicts_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         held_vec[i]    = held_ff[i];
         loading_vec[i] = (status_ff[i] == lsct_pkg::ENT_LOADING);
      end
   end

   // an entry is held exactly while its load is outstanding
   `LSCT_ASSERT_ALWAYS(a_held_is_loading, clock, reset, held_vec == loading_vec)
   `LSCT_ASSERT_NEXT(a_reserve_reports_miss, clock, reset, cmd.do_reserve,
                     rsp_valid_ff && rsp_status_ff == lsct_pkg::RSP_MISS)
   `LSCT_ASSERT_NEXT(a_hit_ticks_clock, clock, reset, cmd.do_hit,
                     use_clock_ff == $past(use_clock_ff) + SW'(1))
   `LSCT_ASSERT_IMPLY(a_complete_cmd_latched, clock, reset, cmd.do_complete, cmd_ff)

endmodule

FILE: hdl/lru_slot_cache_tags.sv
// Fully associative tag store with timestamp LRU replacement, 16 entries.
// Command channel: an item (req_*) is taken at a clock edge where start is
// high and busy is low. req_command 0 looks up req_expert_id and, on a miss,
// reserves a slot; req_command 1 reports the load outcome for req_slot.
// Result channel: each item gives exactly one result beat, shown on rsp_*
// for one cycle with rsp_valid high. The receiver cannot stall it.
// A lookup scans the active entries for a hit; on a miss it scans them again
// for a victim, stopping at the first empty entry, else taking the ready
// entry with the oldest stamp, or reporting no victim when there is none.
// Both scans walk the entry store one entry per cycle through a single read
// port. busy is low again in the cycle the result is shown, so the next item
// can be taken while a result is shown.
// Configuration: one APB register, active_entries at byte 0 (reset 16,
// values above 16 act as 16); write only while the block is idle.
// Reset empties every entry and clears the use clock and all counters.
module lru_slot_cache_tags (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [lsct_pkg::ID_W-1:0]            req_expert_id,
   input  logic [lsct_pkg::SLOT_W-1:0]          req_slot,
   input  logic                                 req_load_ok,
   output logic                                 rsp_valid,
   output logic [lsct_pkg::CODE_W-1:0]          rsp_status,
   output logic [lsct_pkg::SLOT_W-1:0]          rsp_slot_index,
   output logic [lsct_pkg::TOTAL_W-1:0]         rsp_hits_total,
   output logic [lsct_pkg::TOTAL_W-1:0]         rsp_misses_total,
   output logic [lsct_pkg::TOTAL_W-1:0]         rsp_evictions_total,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam logic REG_ACTIVE_ENTRIES = 1'b0;

   logic [lsct_pkg::CFG_W-1:0] active_ff, active_in;
   logic                       csr_wr;
   logic                       csr_hit;
   lsct_pkg::ctl_cmd_type      cmd;
   lsct_pkg::dp_stat_type      stat;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_hit = (paddr[2] == REG_ACTIVE_ENTRIES);

   always_comb begin
      active_in = active_ff;
      if (csr_wr && csr_hit) begin
         active_in = pwdata[lsct_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= lsct_pkg::CFG_W'(lsct_pkg::MAX_ENTRIES);
      end else begin
         active_ff <= active_in;
      end
   end

   assign prdata = csr_hit ? 32'(active_ff) : '0;

   lsct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lsct_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .active_entries      (active_ff),
      .req_command         (req_command),
      .req_expert_id       (req_expert_id),
      .req_slot            (req_slot),
      .req_load_ok         (req_load_ok),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_hits_total      (rsp_hits_total),
      .rsp_misses_total    (rsp_misses_total),
      .rsp_evictions_total (rsp_evictions_total)
   );

endmodule
